[rtl/core/msm_pkg.sv]
// Shared types and constants for the move arrival and stall monitor.
package msm_pkg;

    // Field widths
    localparam int POS_W   = 32;
    localparam int TICK_W  = 32;
    localparam int CNT_W   = 32;
    localparam int TOL_W   = 16;
    localparam int RUN_W   = 8;
    localparam int CFG_W   = 16;
    localparam int S_DATA_W = 104;
    localparam int M_DATA_W = 72;

    // Item kinds carried on s_tuser
    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_MOVING  = 3'd0,
        ST_ARRIVED = 3'd1,
        ST_STALLED = 3'd2,
        ST_ESTOP   = 3'd3,
        ST_STOPPED = 3'd4,
        ST_IDLE    = 3'd5
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ARRIVE_TOL    = 2'd0,
        CFG_STILL_TOL     = 2'd1,
        CFG_STILL_SAMPLES = 2'd2,
        CFG_GRACE_MS      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [TOL_W-1:0] arrive_tolerance;
        logic [TOL_W-1:0] still_tolerance;
        logic [RUN_W-1:0] still_samples;
        logic [TOL_W-1:0] grace_ms;
    } cfg_t;

    typedef struct packed {
        logic              operation;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  position;
        logic              read_ok;
        logic [TICK_W-1:0] tick_ms;
        logic              estop;
        logic              stop_request;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]  move_target;
        logic [POS_W-1:0]  last_position;
        logic              have_last;
        logic [RUN_W-1:0]  still_run;
        logic [TICK_W-1:0] start_time;
        logic              move_active;
        logic              hold_flag;
        logic [POS_W-1:0]  hold_origin;
        logic [CNT_W-1:0]  move_count;
    } mon_state_t;

    typedef struct packed {
        status_t           status;
        logic              stop_drive;
        logic              hold_active;
        logic [POS_W-1:0]  hold_position;
        logic              moving;
        logic [CNT_W-1:0]  finished_moves;
    } result_t;

endpackage

[rtl/core/msm_update.sv]
// Single-pass next-state and result logic for one monitor beat.
module msm_update (
    input  msm_pkg::item_t     item,
    input  msm_pkg::mon_state_t st,
    input  msm_pkg::cfg_t      cfg,
    output msm_pkg::mon_state_t st_next,
    output msm_pkg::result_t   res
);
    import msm_pkg::*;

    logic signed [POS_W:0]  d_arrive;
    logic signed [POS_W:0]  d_still;
    logic signed [POS_W:0]  arrive_lim;
    logic signed [POS_W:0]  still_lim;
    logic                   arrive_hit;
    logic                   still_hit;
    logic [TICK_W-1:0]      elapsed;
    logic                   grace_done;
    logic [RUN_W-1:0]       run_inc;
    logic                   stalled;
    status_t                status;
    logic                   stop_drive;

    // Exact signed distances, checked as a window around zero
    assign d_arrive   = $signed({item.position[POS_W-1], item.position})
                      - $signed({st.move_target[POS_W-1], st.move_target});
    assign d_still    = $signed({item.position[POS_W-1], item.position})
                      - $signed({st.last_position[POS_W-1], st.last_position});
    assign arrive_lim = $signed({{(POS_W+1-TOL_W){1'b0}}, cfg.arrive_tolerance});
    assign still_lim  = $signed({{(POS_W+1-TOL_W){1'b0}}, cfg.still_tolerance});
    assign arrive_hit = (d_arrive <= arrive_lim) && (d_arrive >= -arrive_lim);
    assign still_hit  = (d_still <= still_lim) && (d_still >= -still_lim);

    // Elapsed time wraps with the free running tick
    assign elapsed    = item.tick_ms - st.start_time;
    assign grace_done = elapsed > {{(TICK_W-TOL_W){1'b0}}, cfg.grace_ms};
    assign run_inc    = (st.still_run == {RUN_W{1'b1}}) ? st.still_run
                                                        : st.still_run + 1'b1;

    // Decide the outcome in priority order
    always_comb begin
        st_next    = st;
        status     = ST_MOVING;
        stop_drive = 1'b0;
        stalled    = 1'b0;
        if (item.operation == OP_START) begin
            if (item.estop) begin
                st_next.move_active = 1'b0;
                status              = ST_ESTOP;
            end else begin
                st_next.move_target = item.target;
                st_next.start_time  = item.tick_ms;
                st_next.have_last   = 1'b0;
                st_next.still_run   = '0;
                st_next.move_active = 1'b1;
            end
        end else if (!st.move_active) begin
            status = ST_IDLE;
        end else if (item.estop) begin
            st_next.move_active = 1'b0;
            status              = ST_ESTOP;
        end else if (item.stop_request) begin
            st_next.hold_flag   = 1'b0;
            st_next.move_active = 1'b0;
            stop_drive          = 1'b1;
            status              = ST_STOPPED;
        end else if (item.read_ok) begin
            if (arrive_hit) begin
                st_next.hold_flag   = 1'b0;
                st_next.move_active = 1'b0;
                st_next.move_count  = st.move_count + 1'b1;
                status              = ST_ARRIVED;
            end else begin
                if (st.have_last) begin
                    if (still_hit) begin
                        if (grace_done) begin
                            st_next.still_run = run_inc;
                            stalled           = (run_inc >= cfg.still_samples);
                        end
                    end else begin
                        st_next.still_run = '0;
                    end
                end
                if (stalled) begin
                    stop_drive          = 1'b1;
                    st_next.hold_flag   = 1'b1;
                    st_next.hold_origin = item.position;
                    st_next.move_active = 1'b0;
                    st_next.move_count  = st.move_count + 1'b1;
                    status              = ST_STALLED;
                end else begin
                    st_next.last_position = item.position;
                    st_next.have_last     = 1'b1;
                end
            end
        end
    end

    // Result reflects the state after this beat
    always_comb begin
        res.status         = status;
        res.stop_drive     = stop_drive;
        res.hold_active    = st_next.hold_flag;
        res.hold_position  = st_next.hold_origin;
        res.moving         = st_next.move_active;
        res.finished_moves = st_next.move_count;
    end

endmodule

[rtl/core/move_arrival_stall_monitor_core.sv]
// Top level of the move arrival and stall monitor.
//
// Usage: each slave beat is either a move start (s_tuser = 0) carrying the
// target and time stamp, or a position sample (s_tuser = 1). Every beat
// gives exactly one master beat with the status, stop request, hold origin,
// move flag and the count of finished moves, in input order.
// Path: a beat is captured in an input register and the state update runs
// in one pass into the result register. Throughput is one beat per cycle
// while the receiver does not stall; the only loop is the state update
// from the input register.
// When the receiver stalls, the result register holds and the input
// register takes one more beat; s_tready then drops until m_tready returns.
// Reset (aresetn low, synchronous) clears the monitor state and the move
// count and loads the tolerance, still count and grace time defaults.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at the
// next edge and are meant for when no beat is in flight.
module move_arrival_stall_monitor_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_addr,
    input  logic [msm_pkg::CFG_W-1:0]       cfg_wdata,
    // Input channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tdata: target[31:0], position[63:32], read_ok[64], tick_ms[96:65],
    //        estop[97], stop_request[98], zero pad[103:99]
    input  logic [msm_pkg::S_DATA_W-1:0]    s_tdata,
    // tuser: operation[0]
    input  logic                            s_tuser,
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tdata: status[2:0], stop_drive[3], hold_active[4], hold_position[36:5],
    //        moving[37], finished_moves[69:38], zero pad[71:70]
    output logic [msm_pkg::M_DATA_W-1:0]    m_tdata
);
    import msm_pkg::*;

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       m_valid_reg;
    result_t    res_reg;
    mon_state_t state_reg;
    mon_state_t state_next;
    result_t    res_next;
    cfg_t       cfg_reg;
    item_t      s_item;
    logic       advance;

    // Unpack the slave beat
    always_comb begin
        s_item.operation    = s_tuser;
        s_item.target       = s_tdata[31:0];
        s_item.position     = s_tdata[63:32];
        s_item.read_ok      = s_tdata[64];
        s_item.tick_ms      = s_tdata[96:65];
        s_item.estop        = s_tdata[97];
        s_item.stop_request = s_tdata[98];
    end

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arrive_tolerance <= TOL_W'(5);
            cfg_reg.still_tolerance  <= TOL_W'(1);
            cfg_reg.still_samples    <= RUN_W'(10);
            cfg_reg.grace_ms         <= TOL_W'(1500);
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_addr))
                CFG_ARRIVE_TOL:    cfg_reg.arrive_tolerance <= cfg_wdata;
                CFG_STILL_TOL:     cfg_reg.still_tolerance  <= cfg_wdata;
                CFG_STILL_SAMPLES: cfg_reg.still_samples    <= cfg_wdata[RUN_W-1:0];
                CFG_GRACE_MS:      cfg_reg.grace_ms         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture the slave beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    msm_update u_update (
        .item    (in_item_reg),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Advance the monitor state with each beat that moves to the result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Drive the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, res_reg.finished_moves, res_reg.moving,
                       res_reg.hold_position, res_reg.hold_active,
                       res_reg.stop_drive, res_reg.status};

    // Count a finished move exactly on arrival or stall
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (res_next.status == ST_ARRIVED || res_next.status == ST_STALLED)
        |=> state_reg.move_count == $past(state_reg.move_count) + 1'b1)
        else $error("move count did not step on a finished move");

    // A stall result always stops the drive and holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.status == ST_STALLED
        |-> res_reg.stop_drive && res_reg.hold_active && !res_reg.moving)
        else $error("stall result without stop and hold");

    // Moving status agrees with the move flag
    a_moving_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((res_reg.status == ST_MOVING) == res_reg.moving))
        else $error("moving status and move flag disagree");

    // Input side is never blocked while the result stage is empty
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("input stalled with an empty result stage");

endmodule
